// File: sv/pbr_pkg.sv
// Shared types, codes and constants for the PE base relocation engine.
// No dependencies; every other file imports this package.
package pbr_pkg;

    // Field widths
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned ACTION_W = 2;
    localparam int unsigned OFFSET_W = 33;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned SIZE_W   = 32;
    localparam int unsigned SUM_W    = 34;
    localparam int unsigned ENTRY_OFFS_W = 12;

    // APB register map: registers on an 8-byte stride with 64-bit data
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 64;
    localparam logic REG_DELTA    = 1'b0;
    localparam logic REG_DIR_SIZE = 1'b1;

    // Result queue depth (at least two: one beat may yield two results)
    localparam int unsigned RESULT_DEPTH_DEFAULT = 4;

    // Input kinds
    localparam logic [KIND_W-1:0] KIND_START  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BYTE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TARGET = 2'd2;

    // Result actions
    localparam logic [ACTION_W-1:0] ACT_READ   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_WRITE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FINISH = 2'd2;

    // Finish status
    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_RELOCS   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNSUPPORTED = 2'd2;

    // Directory format
    localparam logic [SIZE_W-1:0] HEADER_BYTES = 32'd8;
    localparam logic [3:0]        TYPE_PAD     = 4'd0;
    localparam logic [3:0]        TYPE_DIR64   = 4'd10;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_HEADER  = 3'd1,
        PH_ENTRIES = 3'd2,
        PH_WAIT    = 3'd3,
        PH_DONE    = 3'd4
    } phase_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [OFFSET_W-1:0] target_offset;
        logic [VALUE_W-1:0]  new_value;
        logic [STATUS_W-1:0] status;
        logic                last;
    } res_t;

    // One accepted input beat as seen by the parser
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [BYTE_W-1:0]  byte_value;
        logic [VALUE_W-1:0] target_value;
    } step_t;

    // Results produced by one beat: zero, one or two
    typedef struct packed {
        logic [1:0] cnt;
        res_t       r0;
        res_t       r1;
    } emit_t;

endpackage

// File: sv/pbr_if.sv
// Valid/ready channel interfaces for the input beats and the result beats.
// Depends on pbr_pkg for field widths.
interface pbr_in_if;
    import pbr_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [BYTE_W-1:0]  byte_value;
    logic [VALUE_W-1:0] target_value;

    modport source (output valid, kind, byte_value, target_value, input ready);
    modport sink   (input valid, kind, byte_value, target_value, output ready);
endinterface

interface pbr_out_if;
    import pbr_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [OFFSET_W-1:0] target_offset;
    logic [VALUE_W-1:0]  new_value;
    logic [STATUS_W-1:0] status;
    logic                last;

    modport source (output valid, action, target_offset, new_value, status, last,
                    input ready);
    modport sink   (input valid, action, target_offset, new_value, status, last,
                    output ready);
endinterface

// File: sv/pbr_parser.sv
// Relocation directory parser: parse state registers and the combinational step logic.
// Depends on pbr_pkg.
module pbr_parser
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step_en,
    input  pbr_pkg::step_t                  step,
    input  logic [pbr_pkg::VALUE_W-1:0]     delta,
    input  logic [pbr_pkg::SIZE_W-1:0]      directory_size,
    output pbr_pkg::emit_t                  emit
);
    import pbr_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [ADDR_W-1:0]   page_reg, page_next;
    logic [SIZE_W-1:0]   blen_reg, blen_next;
    logic [SIZE_W-1:0]   bib_reg, bib_next;
    logic [SUM_W-1:0]    consumed_reg, consumed_next;
    logic [BYTE_W-1:0]   low_reg, low_next;
    logic [OFFSET_W-1:0] pending_reg, pending_next;

    // Parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            page_reg     <= '0;
            blen_reg     <= '0;
            bib_reg      <= '0;
            consumed_reg <= '0;
            low_reg      <= '0;
            pending_reg  <= '0;
        end
        else if (step_en)
        begin
            phase_reg    <= phase_next;
            page_reg     <= page_next;
            blen_reg     <= blen_next;
            bib_reg      <= bib_next;
            consumed_reg <= consumed_next;
            low_reg      <= low_next;
            pending_reg  <= pending_next;
        end
    end

    // Step logic: next state and up to two results
    always_comb
    begin
        logic [2:0]              hdr_idx;
        logic [4:0]              shamt;
        logic [3:0]              etype;
        logic [ENTRY_OFFS_W-1:0] eoffs;
        logic                    do_check;
        res_t                    fin;

        phase_next    = phase_reg;
        page_next     = page_reg;
        blen_next     = blen_reg;
        bib_next      = bib_reg;
        consumed_next = consumed_reg;
        low_next      = low_reg;
        pending_next  = pending_reg;
        emit          = '0;
        do_check      = 1'b0;
        fin           = '0;
        fin.action    = ACT_FINISH;
        hdr_idx       = bib_reg[2:0];
        shamt         = {hdr_idx[1:0], 3'b000};
        etype         = step.byte_value[7:4];
        eoffs         = {step.byte_value[3:0], low_reg};

        case (step.kind)
            KIND_START:
            begin
                page_next     = '0;
                blen_next     = '0;
                bib_next      = '0;
                consumed_next = '0;
                low_next      = '0;
                pending_next  = '0;
                if (directory_size == '0)
                begin
                    phase_next    = PH_DONE;
                    emit.cnt      = 2'd1;
                    emit.r0       = fin;
                    emit.r0.status = ST_NO_RELOCS;
                end
                else
                begin
                    phase_next = PH_HEADER;
                end
            end
            KIND_BYTE:
            begin
                if (phase_reg == PH_HEADER)
                begin
                    // little-endian page address, then block size
                    if (!hdr_idx[2])
                        page_next = page_reg | (ADDR_W'(step.byte_value) << shamt);
                    else
                        blen_next = blen_reg | (SIZE_W'(step.byte_value) << shamt);
                    bib_next = SIZE_W'(hdr_idx) + SIZE_W'(1);
                    if (hdr_idx == 3'd7)
                    begin
                        if (blen_next < HEADER_BYTES)
                        begin
                            phase_next     = PH_DONE;
                            emit.cnt       = 2'd1;
                            emit.r0        = fin;
                            emit.r0.status = ST_UNSUPPORTED;
                        end
                        else
                        begin
                            do_check = 1'b1;
                        end
                    end
                end
                else if (phase_reg == PH_ENTRIES)
                begin
                    bib_next = bib_reg + SIZE_W'(1);
                    if (!bib_reg[0])
                    begin
                        // low byte of an entry; an odd trailing byte is dropped
                        if (bib_next != blen_reg)
                            low_next = step.byte_value;
                        do_check = 1'b1;
                    end
                    else if (etype == TYPE_PAD)
                    begin
                        do_check = 1'b1;
                    end
                    else if (etype != TYPE_DIR64)
                    begin
                        phase_next     = PH_DONE;
                        emit.cnt       = 2'd1;
                        emit.r0        = fin;
                        emit.r0.status = ST_UNSUPPORTED;
                    end
                    else
                    begin
                        pending_next = OFFSET_W'(page_reg) + OFFSET_W'(eoffs);
                        phase_next   = PH_WAIT;
                        emit.cnt     = 2'd1;
                        emit.r0.action        = ACT_READ;
                        emit.r0.target_offset = pending_next;
                    end
                end
            end
            KIND_TARGET:
            begin
                if (phase_reg == PH_WAIT)
                begin
                    emit.cnt              = 2'd1;
                    emit.r0.action        = ACT_WRITE;
                    emit.r0.target_offset = pending_reg;
                    emit.r0.new_value     = step.target_value + delta;
                    do_check              = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // Block end: add its size to the running total, maybe finish the pass
        if (do_check)
        begin
            if (bib_next == blen_next)
            begin
                consumed_next = consumed_reg + SUM_W'(blen_next);
                bib_next      = '0;
                if (consumed_next >= SUM_W'(directory_size))
                begin
                    phase_next = PH_DONE;
                    fin.status = ST_OK;
                    if (emit.cnt == 2'd0)
                        emit.r0 = fin;
                    else
                        emit.r1 = fin;
                    emit.cnt = emit.cnt + 2'd1;
                end
                else
                begin
                    phase_next = PH_HEADER;
                    page_next  = '0;
                    blen_next  = '0;
                end
            end
            else
            begin
                phase_next = PH_ENTRIES;
            end
        end

        // Mark the final result of this beat
        if (emit.cnt == 2'd1)
            emit.r0.last = 1'b1;
        else if (emit.cnt == 2'd2)
            emit.r1.last = 1'b1;

        if (!step_en)
            emit.cnt = 2'd0;
    end

endmodule

// File: sv/pbr_result_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per beat.
// Depends on pbr_pkg for the result type.
module pbr_result_fifo
#(
    parameter int unsigned DEPTH = pbr_pkg::RESULT_DEPTH_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [1:0]    push_cnt,
    input  pbr_pkg::res_t push0,
    input  pbr_pkg::res_t push1,
    output logic          room,
    output logic          head_valid,
    input  logic          head_ready,
    output pbr_pkg::res_t head_data
);
    import pbr_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    res_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] wr_ptr_inc;
    logic          pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign wr_ptr_inc = ptr_inc(wr_ptr_reg);
    assign pop        = head_valid && head_ready;
    assign head_valid = (count_reg != '0);
    assign head_data  = mem[rd_ptr_reg];
    assign room       = (count_reg <= CW'(DEPTH - 2));

    // Pointer and fill bookkeeping
    always_comb
    begin
        count_next  = count_reg + CW'(push_cnt) - CW'(pop);
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        case (push_cnt)
            2'd1:    wr_ptr_next = wr_ptr_inc;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_inc);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            mem[wr_ptr_reg] <= push0;
        if (push_cnt == 2'd2)
            mem[wr_ptr_inc] <= push1;
    end

endmodule

// File: sv/pe_base_reloc_engine.sv
// Top level of the PE base relocation engine: APB registers, input register,
// parser and result queue. Depends on pbr_pkg, pbr_if, pbr_parser, pbr_result_fifo.
//
//   channel   dir  handshake      beat carries
//   items     in   valid/ready    kind, byte_value, target_value
//   results   out  valid/ready    action, target_offset, new_value, status, last
//   apb       in   psel/penable   delta @0x0, directory_size @0x8 (64-bit data)
//
// Each input beat is registered, then parsed; one beat per cycle is sustained while
// the queue has room. A beat yields at most two results, pushed into a queue of
// RESULT_DEPTH entries; the parse step waits while fewer than two slots are free.
// A stalled result side holds the input register and drops items.ready.
// Reset (rst_n low) clears parse state, queue and registers; no clearing pass.
module pe_base_reloc_engine
#(
    parameter int unsigned RESULT_DEPTH = pbr_pkg::RESULT_DEPTH_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    pbr_in_if.sink                            items,
    pbr_out_if.source                         results,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pbr_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [pbr_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [pbr_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import pbr_pkg::*;

    logic [VALUE_W-1:0] delta_reg;
    logic [SIZE_W-1:0]  dir_size_reg;
    logic               in_vld_reg;
    step_t              step_reg;
    logic               fifo_room;
    logic               fire;
    emit_t              emit;
    res_t               head;
    logic               cfg_wr;

    // APB registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[3] == REG_DIR_SIZE) ? APB_DATA_W'(dir_size_reg)
                                               : APB_DATA_W'(delta_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delta_reg    <= '0;
            dir_size_reg <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[3] == REG_DELTA)
                delta_reg <= pwdata[VALUE_W-1:0];
            else
                dir_size_reg <= pwdata[SIZE_W-1:0];
        end
    end

    // Input register: parse fires when the queue can take two results
    assign fire        = in_vld_reg && fifo_room;
    assign items.ready = !in_vld_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (items.ready)
            in_vld_reg <= items.valid;
    end

    always_ff @(posedge clk)
    begin
        if (items.valid && items.ready)
        begin
            step_reg.kind         <= items.kind;
            step_reg.byte_value   <= items.byte_value;
            step_reg.target_value <= items.target_value;
        end
    end

    pbr_parser u_parser
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .step_en        (fire),
        .step           (step_reg),
        .delta          (delta_reg),
        .directory_size (dir_size_reg),
        .emit           (emit)
    );

    pbr_result_fifo #(.DEPTH(RESULT_DEPTH)) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cnt   (emit.cnt),
        .push0      (emit.r0),
        .push1      (emit.r1),
        .room       (fifo_room),
        .head_valid (results.valid),
        .head_ready (results.ready),
        .head_data  (head)
    );

    assign results.action        = head.action;
    assign results.target_offset = head.target_offset;
    assign results.new_value     = head.new_value;
    assign results.status        = head.status;
    assign results.last          = head.last;

`ifndef ASSERT_OFF
    // Two results from one beat: only the second one closes the beat
    a_two_results_last: assert property (@(posedge clk) disable iff (!rst_n)
        emit.cnt == 2'd2 |-> !emit.r0.last && emit.r1.last)
        else $error("two-result beat with wrong last marking");

    // A write result only comes from a read-back beat
    a_write_from_target: assert property (@(posedge clk) disable iff (!rst_n)
        emit.cnt != 2'd0 && emit.r0.action == ACT_WRITE |-> step_reg.kind == KIND_TARGET)
        else $error("write result from a beat that is not a read-back");

    // A held input beat stays put until the parser takes it
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && !fifo_room |=> in_vld_reg && $stable(step_reg))
        else $error("input register changed while stalled");
`endif

endmodule
